### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros of the checker file
// Clocked property wrappers; the scope must provide i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check at every rising edge, skip while reset is low.
`define MFS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mfs assertion failed");

// Check at every rising edge, reset included.
`define MFS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("mfs assertion failed");

`endif

### design/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg
// Constants, codes, state type and fixed-point helpers of the scheduler math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfs_pkg;

    // 17.14 fixed point
    localparam int FRAC_BITS = 14;
    localparam int FRAC_ONE  = 1 << FRAC_BITS;

    // Load update factors 59/60 and 1/60, truncated
    localparam logic signed [31:0] K59 = 32'((59 * FRAC_ONE) / 60);
    localparam logic signed [31:0] K1  = 32'(FRAC_ONE / 60);
    localparam logic signed [31:0] K100 = 32'sd100;

    // Decay divider: dividend is 2*la scaled by FRAC_ONE
    localparam int DIV_W = 32 + FRAC_BITS;

    // Width of round(cpu usage/4) and of the raw priority
    localparam int RND_W = 32 - FRAC_BITS;
    localparam int PRI_W = RND_W + 2;

    // Reset values of the configuration registers
    localparam logic [7:0] TOP_RESET    = 8'd63;
    localparam logic [7:0] BOTTOM_RESET = 8'd0;

    // Operation codes
    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_LOAD   = 3'd1;
    localparam logic [2:0] FN_DECAY  = 3'd2;
    localparam logic [2:0] FN_PRIO   = 3'd3;
    localparam logic [2:0] FN_REPORT = 3'd4;

    // Configuration register indexes
    localparam logic CFG_TOP    = 1'b0;
    localparam logic CFG_BOTTOM = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LA_MUL,
        ST_LA_ACC,
        ST_LA_ADD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RC_MUL,
        ST_RC_ADD,
        ST_PRI_RND,
        ST_PRI_CLAMP,
        ST_REP_LA,
        ST_REP_RC,
        ST_REP_FIN,
        ST_DONE
    } t_state;

    // Product / FRAC_ONE truncated toward zero, wrapped to 32 bits
    function automatic logic signed [31:0] fx_trunc(input logic signed [63:0] p);
        logic signed [63:0] b;
        b = p + (p[63] ? 64'(FRAC_ONE - 1) : 64'sd0);
        return 32'(b >>> FRAC_BITS);
    endfunction

    // Round to nearest integer, halves away from zero, with 32-bit wrap
    function automatic logic signed [31:0] round_near(input logic signed [31:0] n);
        logic signed [31:0] t;
        logic signed [31:0] b;
        if (n > 32'sd0) begin
            t = n + 32'(FRAC_ONE / 2);
        end else begin
            t = n - 32'(FRAC_ONE / 2);
        end
        b = t + (t[31] ? 32'(FRAC_ONE - 1) : 32'sd0);
        return b >>> FRAC_BITS;
    endfunction

endpackage

### design/mlfq_fixed_point_scheduler_math.sv
// ----------------------------------------------------------------------------
// mlfq_fixed_point_scheduler_math
// Fixed-point (17.14) arithmetic engine of a multi-level feedback queue
// scheduler; holds the system load average.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. The engine works on one item at a
// time and drops o_ready from acceptance until its result has been moved into
// the output register; a finished result may wait there while the next item
// is already being accepted and worked on. Tick and unused codes, and decay of
// an idle thread, go straight to the done step; load update, priority and
// report pass through their sequencer steps; any other decay waits on the
// divider, which is skipped with a zero decay factor when 2*load average
// + 1.0 wraps to zero. The divider yields one quotient bit per cycle over
// a 46-bit dividend. All multiplications go through a single registered
// 32x32 multiplier that the sequencer reuses step after step. Results wrap
// at 32 bits. Write top_priority (index 0) and bottom_priority (index 1)
// only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlfq_fixed_point_scheduler_math (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_cpu_usage,
    input  logic signed [5:0]  i_nice,
    input  logic               i_is_idle,
    input  logic [9:0]         i_ready_count,
    // output channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_cpu_usage_out,
    output logic [7:0]         o_priority_out,
    output logic signed [31:0] o_sys_load_out,
    output logic signed [31:0] o_sys_load_x100,
    output logic signed [31:0] o_cpu_usage_x100
);

    localparam int FB    = mfs_pkg::FRAC_BITS;
    localparam int RND_W = mfs_pkg::RND_W;
    localparam int PRI_W = mfs_pkg::PRI_W;
    localparam int DW    = mfs_pkg::DIV_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    mfs_pkg::t_state r_state, n_state;

    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_la, n_la;
    logic [7:0]         r_top, n_top;
    logic [7:0]         r_bot, n_bot;

    // latched transaction
    logic signed [31:0] r_rc, n_rc;
    logic signed [5:0]  r_nice, n_nice;
    logic               r_idle, n_idle;
    logic [9:0]         r_rdy_cnt, n_rdy_cnt;

    // working results
    logic signed [31:0]      r_acc, n_acc;
    logic signed [RND_W-1:0] r_rnd, n_rnd;
    logic signed [31:0]      r_rc_res, n_rc_res;
    logic [7:0]              r_prio, n_prio;
    logic signed [31:0]      r_lax, n_lax;
    logic signed [31:0]      r_rcx, n_rcx;

    // output register
    logic signed [31:0] r_o_rc, n_o_rc;
    logic [7:0]         r_o_prio, n_o_prio;
    logic signed [31:0] r_o_la, n_o_la;
    logic signed [31:0] r_o_lax, n_o_lax;
    logic signed [31:0] r_o_rcx, n_o_rcx;

    // ------------------------------------------------------------------
    // Shared units and helper terms
    // ------------------------------------------------------------------
    logic               in_acc;
    logic               out_load;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quot;

    logic signed [31:0]      twice_la;
    logic signed [31:0]      den;
    logic signed [DW-1:0]    dividend;
    logic [10:0]             rdy_eff;
    logic signed [31:0]      nice_fx;
    logic signed [31:0]      quarter;
    logic signed [31:0]      rnd_full;
    logic signed [PRI_W-1:0] pri_raw;
    logic signed [PRI_W-1:0] top_s;
    logic signed [PRI_W-1:0] bot_s;

    assign in_acc   = i_valid && o_ready;
    assign out_load = (r_state == mfs_pkg::ST_DONE) && (!r_out_valid || i_ready);

    assign twice_la = {r_la[30:0], 1'b0};
    assign den      = twice_la + 32'(mfs_pkg::FRAC_ONE);
    assign dividend = {twice_la, {FB{1'b0}}};
    assign rdy_eff  = {1'b0, r_rdy_cnt} + {10'd0, !r_idle};
    assign nice_fx  = 32'(r_nice) <<< FB;

    // cpu usage / 4, truncated toward zero, then rounded to an integer
    assign quarter  = (r_rc + (r_rc[31] ? 32'sd3 : 32'sd0)) >>> 2;
    assign rnd_full = mfs_pkg::round_near(quarter);

    assign top_s   = PRI_W'($signed({1'b0, r_top}));
    assign bot_s   = PRI_W'($signed({1'b0, r_bot}));
    assign pri_raw = top_s - PRI_W'(r_rnd) - PRI_W'($signed({r_nice, 1'b0}));

    assign div_start = (r_state == mfs_pkg::ST_DIV_START) && (den != 32'sd0);

    // Steer the shared multiplier by sequencer step
    always_comb begin
        case (r_state)
            mfs_pkg::ST_LA_ACC: begin
                mul_a = 32'($signed({1'b0, rdy_eff}));
                mul_b = mfs_pkg::K1;
            end
            mfs_pkg::ST_RC_MUL: begin
                mul_a = r_acc;
                mul_b = r_rc;
            end
            mfs_pkg::ST_REP_LA: begin
                mul_a = r_la;
                mul_b = mfs_pkg::K100;
            end
            mfs_pkg::ST_REP_RC: begin
                mul_a = r_rc;
                mul_b = mfs_pkg::K100;
            end
            default: begin
                mul_a = r_la;
                mul_b = mfs_pkg::K59;
            end
        endcase
    end

    mfs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    mfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (den),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            mfs_pkg::ST_IDLE: begin
                if (i_valid) begin
                    case (i_func)
                        mfs_pkg::FN_LOAD:   n_state = mfs_pkg::ST_LA_MUL;
                        mfs_pkg::FN_DECAY:  n_state = i_is_idle ? mfs_pkg::ST_DONE
                                                                : mfs_pkg::ST_DIV_START;
                        mfs_pkg::FN_PRIO:   n_state = mfs_pkg::ST_PRI_RND;
                        mfs_pkg::FN_REPORT: n_state = mfs_pkg::ST_REP_LA;
                        default:            n_state = mfs_pkg::ST_DONE;
                    endcase
                end
            end
            mfs_pkg::ST_LA_MUL:    n_state = mfs_pkg::ST_LA_ACC;
            mfs_pkg::ST_LA_ACC:    n_state = mfs_pkg::ST_LA_ADD;
            mfs_pkg::ST_LA_ADD:    n_state = mfs_pkg::ST_DONE;
            mfs_pkg::ST_DIV_START: n_state = (den == 32'sd0) ? mfs_pkg::ST_RC_MUL
                                                             : mfs_pkg::ST_DIV_WAIT;
            mfs_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = mfs_pkg::ST_RC_MUL;
                end
            end
            mfs_pkg::ST_RC_MUL:    n_state = mfs_pkg::ST_RC_ADD;
            mfs_pkg::ST_RC_ADD:    n_state = mfs_pkg::ST_DONE;
            mfs_pkg::ST_PRI_RND:   n_state = mfs_pkg::ST_PRI_CLAMP;
            mfs_pkg::ST_PRI_CLAMP: n_state = mfs_pkg::ST_DONE;
            mfs_pkg::ST_REP_LA:    n_state = mfs_pkg::ST_REP_RC;
            mfs_pkg::ST_REP_RC:    n_state = mfs_pkg::ST_REP_FIN;
            mfs_pkg::ST_REP_FIN:   n_state = mfs_pkg::ST_DONE;
            mfs_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = mfs_pkg::ST_IDLE;
                end
            end
            default:               n_state = mfs_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath updates
    // ------------------------------------------------------------------
    always_comb begin
        n_la      = r_la;
        n_top     = r_top;
        n_bot     = r_bot;
        n_rc      = r_rc;
        n_nice    = r_nice;
        n_idle    = r_idle;
        n_rdy_cnt = r_rdy_cnt;
        n_acc     = r_acc;
        n_rnd     = r_rnd;
        n_rc_res  = r_rc_res;
        n_prio    = r_prio;
        n_lax     = r_lax;
        n_rcx     = r_rcx;

        case (r_state)
            mfs_pkg::ST_IDLE: begin
                // Latch the transaction; tick finishes right here
                if (in_acc) begin
                    n_rc      = i_cpu_usage;
                    n_nice    = i_nice;
                    n_idle    = i_is_idle;
                    n_rdy_cnt = i_ready_count;
                    n_prio    = '0;
                    n_lax     = '0;
                    n_rcx     = '0;
                    if ((i_func == mfs_pkg::FN_TICK) && !i_is_idle) begin
                        n_rc_res = i_cpu_usage + 32'(mfs_pkg::FRAC_ONE);
                    end else begin
                        n_rc_res = i_cpu_usage;
                    end
                end
            end
            mfs_pkg::ST_LA_ACC: n_acc = mfs_pkg::fx_trunc(prod);
            mfs_pkg::ST_LA_ADD: n_la  = r_acc + prod[31:0];
            mfs_pkg::ST_DIV_START: begin
                // zero divisor: decay factor is zero
                if (den == 32'sd0) begin
                    n_acc = '0;
                end
            end
            mfs_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_acc = div_quot;
                end
            end
            mfs_pkg::ST_RC_ADD:  n_rc_res = mfs_pkg::fx_trunc(prod) + nice_fx;
            mfs_pkg::ST_PRI_RND: n_rnd = rnd_full[RND_W-1:0];
            mfs_pkg::ST_PRI_CLAMP: begin
                // ceiling checked first; raw above top always gets top
                if (pri_raw > top_s) begin
                    n_prio = r_top;
                end else if (pri_raw < bot_s) begin
                    n_prio = r_bot;
                end else begin
                    n_prio = pri_raw[7:0];
                end
            end
            mfs_pkg::ST_REP_RC:  n_lax = mfs_pkg::round_near(prod[31:0]);
            mfs_pkg::ST_REP_FIN: n_rcx = mfs_pkg::round_near(prod[31:0]);
            default: begin
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                mfs_pkg::CFG_TOP:    n_top = i_cfg_data;
                mfs_pkg::CFG_BOTTOM: n_bot = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold while stalled, load from the DONE step
    // ------------------------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_o_rc      = r_o_rc;
        n_o_prio    = r_o_prio;
        n_o_la      = r_o_la;
        n_o_lax     = r_o_lax;
        n_o_rcx     = r_o_rcx;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_o_rc      = r_rc_res;
            n_o_prio    = r_prio;
            n_o_la      = r_la;
            n_o_lax     = r_lax;
            n_o_rcx     = r_rcx;
        end
    end

    // control state and load average
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_la        <= '0;
            r_top       <= mfs_pkg::TOP_RESET;
            r_bot       <= mfs_pkg::BOTTOM_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_la        <= n_la;
            r_top       <= n_top;
            r_bot       <= n_bot;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rc      <= n_rc;
        r_nice    <= n_nice;
        r_idle    <= n_idle;
        r_rdy_cnt <= n_rdy_cnt;
        r_acc     <= n_acc;
        r_rnd     <= n_rnd;
        r_rc_res  <= n_rc_res;
        r_prio    <= n_prio;
        r_lax     <= n_lax;
        r_rcx     <= n_rcx;
        r_o_rc    <= n_o_rc;
        r_o_prio  <= n_o_prio;
        r_o_la    <= n_o_la;
        r_o_lax   <= n_o_lax;
        r_o_rcx   <= n_o_rcx;
    end

    assign o_ready          = (r_state == mfs_pkg::ST_IDLE);
    assign o_valid          = r_out_valid;
    assign o_cpu_usage_out  = r_o_rc;
    assign o_priority_out   = r_o_prio;
    assign o_sys_load_out   = r_o_la;
    assign o_sys_load_x100  = r_o_lax;
    assign o_cpu_usage_x100 = r_o_rcx;

endmodule

### design/mfs_mul.sv
// ----------------------------------------------------------------------------
// mfs_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfs_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_prod
);

    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

### design/mfs_div.sv
// ----------------------------------------------------------------------------
// mfs_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero; the quotient is wrapped to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfs_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [mfs_pkg::DIV_W-1:0]   i_dividend,
    input  logic signed [31:0]                 i_divisor,
    output logic                               o_done,
    output logic signed [31:0]                 o_quot
);

    localparam int DW    = mfs_pkg::DIV_W;
    localparam int CNT_W = $clog2(DW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [DW-1:0]    r_q;
    logic [31:0]      r_dsr;
    logic             r_neg;

    logic [32:0]      trial;
    logic [32:0]      diff;
    logic             fits;
    logic [DW-1:0]    dvd_mag;
    logic [31:0]      dsr_mag;

    assign dvd_mag = i_dividend[DW-1] ? (DW'(~i_dividend) + DW'(1)) : DW'(i_dividend);
    assign dsr_mag = i_divisor[31] ? (~i_divisor + 32'd1) : i_divisor;

    // Restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_rem, r_q[DW-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign fits  = (trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= dvd_mag;
            r_dsr <= dsr_mag;
            r_neg <= i_dividend[DW-1] ^ i_divisor[31];
        end else if (r_busy) begin
            r_rem <= fits ? diff[31:0] : trial[31:0];
            r_q   <= {r_q[DW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(~r_q[31:0] + 32'd1) : $signed(r_q[31:0]);

endmodule

### design/mfs_checker.sv
// ----------------------------------------------------------------------------
// mfs_checker
// Port-level checks of the scheduler math block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_cpu_usage_out,
    input logic [7:0]         o_priority_out,
    input logic signed [31:0] o_sys_load_out,
    input logic signed [31:0] o_sys_load_x100,
    input logic signed [31:0] o_cpu_usage_x100
);

    // whole result payload, for the hold check
    logic [135:0] out_word;

    assign out_word = {o_cpu_usage_out, o_priority_out, o_sys_load_out,
                       o_sys_load_x100, o_cpu_usage_x100};

    // Reset leaves the block empty and ready
    `MFS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!o_valid && o_ready))

    // One item at a time: busy right after an accepted transaction
    `MFS_ASSERT(a_busy_after_accept, (i_valid && o_ready) |=> !o_ready)

    // No result can appear in the cycle right after acceptance
    `MFS_ASSERT(a_min_latency, (i_valid && o_ready && !o_valid) |=> !o_valid)

    // Stalled result holds
    `MFS_ASSERT(a_out_hold, (o_valid && !i_ready) |=> (o_valid && $stable(out_word)))

    // A report and a priority never come from the same transaction
    `MFS_ASSERT(a_report_or_prio, o_valid |-> (o_priority_out == 8'd0 || (o_sys_load_x100 == 32'sd0 && o_cpu_usage_x100 == 32'sd0)))

endmodule

bind mlfq_fixed_point_scheduler_math mfs_checker u_mfs_checker (.*);
